// File: rtl/core/bfws_pkg.sv
// Package for the box filter window sum block.
// Holds field widths, default parameter values and register codes.
// No dependencies.
`timescale 1ns / 1ps

package bfws_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HALF_H = 15;
  localparam int DEF_MAX_HALF_W = 15;
  localparam int DEF_PIXEL_BITS = 8;

  localparam int IN_PIXEL_W   = 8;
  localparam int SUM_W        = 18;
  localparam int COLSUM_W     = 13;
  localparam int ROW_W        = 13;
  localparam int CROW_W       = 12;
  localparam int CCOL_W       = 10;
  localparam int HALF_W       = 4;
  localparam int CMP_W        = 16;
  localparam int WIDTH_CFG_W  = 11;
  localparam int HEIGHT_CFG_W = 13;
  localparam int WIN_CFG_W    = 5;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 2;
  localparam int HEIGHT_LIMIT = 4096;

  localparam logic [WIDTH_CFG_W-1:0]  RST_IMAGE_WIDTH  = 11'd640;
  localparam logic [HEIGHT_CFG_W-1:0] RST_IMAGE_HEIGHT = 13'd480;
  localparam logic [WIN_CFG_W-1:0]    RST_WINDOW       = 5'd3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_WINDOW_HEIGHT = 2'd2,
    REG_WINDOW_WIDTH  = 2'd3
  } cfg_reg_t;

endpackage

// File: rtl/core/bfws_in_if.sv
// Input channel of the box filter window sum block: one pixel per transaction.
// Depends on bfws_pkg.
`timescale 1ns / 1ps

interface bfws_in_if;
  logic                              valid;
  logic                              ready;
  logic [bfws_pkg::IN_PIXEL_W-1:0]   pixel;
  logic                              start_of_frame;

  modport source (output valid, pixel, start_of_frame, input ready);
  modport sink   (input valid, pixel, start_of_frame, output ready);
endinterface

// File: rtl/core/bfws_out_if.sv
// Output channel of the box filter window sum block: one window sum per transaction.
// Depends on bfws_pkg.
`timescale 1ns / 1ps

interface bfws_out_if;
  logic                          valid;
  logic                          ready;
  logic [bfws_pkg::SUM_W-1:0]    box_sum;
  logic [bfws_pkg::CROW_W-1:0]   centre_row;
  logic [bfws_pkg::CCOL_W-1:0]   centre_col;
  logic                          frame_done;

  modport source (output valid, box_sum, centre_row, centre_col, frame_done, input ready);
  modport sink   (input valid, box_sum, centre_row, centre_col, frame_done, output ready);
endinterface

// File: rtl/core/box_filter_window_sum.sv
// Top level of the box filter window sum block.
// Depends on bfws_pkg, bfws_in_if and bfws_out_if.
//
// channel   | direction | transaction
// pix_in    | in        | one pixel or flush item in raster order
// res_out   | out       | one clipped window sum with its centre position
// cfg_*     | in        | one register write, no handshake
//
// One pixel is taken per cycle while pix_in is not held off; a result passes
// through the second-stage registers and the output register. At the end of
// each row from row hh on, the right-edge centres leave one per cycle while
// res_out is not stalled; pix_in is held off while they leave and in the cycle
// that starts them, as they share the single output and running row sum registers.
// Reset is synchronous; the line stores need no clearing pass.
// A stalled res_out holds the pipeline and, through it, pix_in.
`timescale 1ns / 1ps

module box_filter_window_sum #(
  parameter int MAX_WIDTH  = bfws_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HALF_H = bfws_pkg::DEF_MAX_HALF_H,
  parameter int MAX_HALF_W = bfws_pkg::DEF_MAX_HALF_W,
  parameter int PIXEL_BITS = bfws_pkg::DEF_PIXEL_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  bfws_in_if.sink                             pix_in,
  bfws_out_if.source                          res_out,
  input  logic                                cfg_write,
  input  logic [bfws_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bfws_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int WB    = $clog2(MAX_WIDTH + 1);
  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RING  = 2 * MAX_HALF_H + 1;
  localparam int SB    = $clog2(RING + 1);
  localparam int DEPTH = RING * MAX_WIDTH;
  localparam int AB    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW    = 2 * MAX_HALF_W + 2;
  localparam int TB    = $clog2(LW);
  localparam int RW    = bfws_pkg::ROW_W;
  localparam int CSW   = bfws_pkg::COLSUM_W;
  localparam int SW    = bfws_pkg::SUM_W;
  localparam int HW    = bfws_pkg::HALF_W;
  localparam int MW    = bfws_pkg::CMP_W;

  logic [bfws_pkg::WIDTH_CFG_W-1:0]  image_width;
  logic [bfws_pkg::HEIGHT_CFG_W-1:0] image_height;
  logic [bfws_pkg::WIN_CFG_W-1:0]    window_height;
  logic [bfws_pkg::WIN_CFG_W-1:0]    window_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= bfws_pkg::RST_IMAGE_WIDTH;
      image_height  <= bfws_pkg::RST_IMAGE_HEIGHT;
      window_height <= bfws_pkg::RST_WINDOW;
      window_width  <= bfws_pkg::RST_WINDOW;
    end else if (cfg_write) begin
      unique case (bfws_pkg::cfg_reg_t'(cfg_index))
        bfws_pkg::REG_IMAGE_WIDTH:   image_width   <= cfg_data[bfws_pkg::WIDTH_CFG_W-1:0];
        bfws_pkg::REG_IMAGE_HEIGHT:  image_height  <= cfg_data;
        bfws_pkg::REG_WINDOW_HEIGHT: window_height <= cfg_data[bfws_pkg::WIN_CFG_W-1:0];
        bfws_pkg::REG_WINDOW_WIDTH:  window_width  <= cfg_data[bfws_pkg::WIN_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  logic [WB-1:0] w;
  logic [RW-1:0] h;
  logic [HW-1:0] hh_raw, hw_raw, hh, hw;
  logic [MW-1:0] w_m, h_m, hh_m, hw_m, vlim_m, two_hh1_m, two_hw1_m;
  logic [SB-1:0] slot_last;

  always_comb begin
    if (image_width == '0) begin
      w = WB'(1);
    end else if (int'(image_width) > MAX_WIDTH) begin
      w = WB'(MAX_WIDTH);
    end else begin
      w = WB'(image_width);
    end
    if (image_height == '0) begin
      h = RW'(1);
    end else if (int'(image_height) > bfws_pkg::HEIGHT_LIMIT) begin
      h = RW'(bfws_pkg::HEIGHT_LIMIT);
    end else begin
      h = image_height;
    end
    hh_raw = window_height[bfws_pkg::WIN_CFG_W-1:1];
    hw_raw = window_width[bfws_pkg::WIN_CFG_W-1:1];
    hh = (int'(hh_raw) > MAX_HALF_H) ? HW'(MAX_HALF_H) : hh_raw;
    hw = (int'(hw_raw) > MAX_HALF_W) ? HW'(MAX_HALF_W) : hw_raw;
    w_m       = MW'(w);
    h_m       = MW'(h);
    hh_m      = MW'(hh);
    hw_m      = MW'(hw);
    vlim_m    = h_m + hh_m;
    two_hh1_m = {hh_m[MW-2:0], 1'b0} + MW'(1);
    two_hw1_m = {hw_m[MW-2:0], 1'b0} + MW'(1);
    slot_last = SB'({hh, 1'b0});
  end

  // Scan position and ring row of the next item.
  logic [RW-1:0] scan_row;
  logic [WB-1:0] scan_col;
  logic [SB-1:0] scan_slot;
  logic [AB-1:0] scan_base;

  logic [RW-1:0] v0;
  logic [WB-1:0] u0;
  logic [SB-1:0] slot0;
  logic [AB-1:0] base0;
  logic [RW-1:0] scan_row_next;
  logic [WB-1:0] scan_col_next;
  logic [SB-1:0] scan_slot_next;
  logic [AB-1:0] scan_base_next;
  logic [PIXEL_BITS-1:0] p0;
  logic [AB-1:0] addr0;

  always_comb begin
    if (pix_in.start_of_frame) begin
      v0 = '0;
      u0 = '0;
      slot0 = '0;
      base0 = '0;
    end else begin
      v0 = scan_row;
      u0 = scan_col;
      slot0 = scan_slot;
      base0 = scan_base;
    end
    if (MW'(u0) >= w_m) begin
      u0 = '0;
      v0 = v0 + RW'(1);
      if (slot0 == slot_last) begin
        slot0 = '0;
        base0 = '0;
      end else begin
        slot0 = slot0 + SB'(1);
        base0 = base0 + AB'(MAX_WIDTH);
      end
    end
    if (MW'(v0) >= vlim_m) begin
      v0 = '0;
      slot0 = '0;
      base0 = '0;
    end
    p0 = (MW'(v0) < h_m) ? PIXEL_BITS'(pix_in.pixel) : '0;
    addr0 = base0 + AB'(u0);

    scan_row_next  = v0;
    scan_col_next  = u0 + WB'(1);
    scan_slot_next = slot0;
    scan_base_next = base0;
    if (MW'(scan_col_next) >= w_m) begin
      scan_col_next = '0;
      scan_row_next = v0 + RW'(1);
      if (slot0 == slot_last) begin
        scan_slot_next = '0;
        scan_base_next = '0;
      end else begin
        scan_slot_next = slot0 + SB'(1);
        scan_base_next = base0 + AB'(MAX_WIDTH);
      end
      if (MW'(scan_row_next) >= vlim_m) begin
        scan_row_next  = '0;
        scan_slot_next = '0;
        scan_base_next = '0;
      end
    end
  end

  logic accept;
  assign accept = pix_in.valid && pix_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_row  <= '0;
      scan_col  <= '0;
      scan_slot <= '0;
      scan_base <= '0;
    end else if (accept) begin
      scan_row  <= scan_row_next;
      scan_col  <= scan_col_next;
      scan_slot <= scan_slot_next;
      scan_base <= scan_base_next;
    end
  end

  // Second stage: update of the line stores and the running sums.
  logic                  s1_valid;
  logic [RW-1:0]         s1_row;
  logic [WB-1:0]         s1_col;
  logic [PIXEL_BITS-1:0] s1_pix;
  logic [AB-1:0]         s1_addr;
  logic [PIXEL_BITS-1:0] pix_rd;
  logic [CSW-1:0]        col_rd;

  logic [PIXEL_BITS-1:0] pix_mem [DEPTH];
  logic [CSW-1:0]        col_mem [MAX_WIDTH];

  logic [CSW-1:0] line_q [LW];
  logic [SW-1:0]  row_sum;
  logic           tail_active;
  logic [WB-1:0]  tail_col;
  logic [RW-1:0]  tail_row;
  logic           out_valid;
  logic           out_free;

  logic [PIXEL_BITS-1:0] old_pix;
  logic [CSW-1:0] cs_new;
  logic [CSW-1:0] tap;
  logic [SW-1:0]  rs_new, rs_tail;
  logic           emit1, s1_go, tail_go, tail_step;
  logic [MW-1:0]  s1_col_m, s1_row_m, tail_start_m;

  assign out_free = !out_valid || res_out.ready;

  always_comb begin
    s1_row_m = MW'(s1_row);
    s1_col_m = MW'(s1_col);
    old_pix  = (s1_row_m >= two_hh1_m) ? pix_rd : '0;
    if (s1_row == '0) begin
      cs_new = CSW'(s1_pix);
    end else begin
      cs_new = col_rd + CSW'(s1_pix) - CSW'(old_pix);
    end
    tap = line_q[TB'({hw, 1'b0})];
    rs_new = ((s1_col == '0) ? '0 : row_sum) + SW'(cs_new)
           - ((s1_col_m >= two_hw1_m) ? SW'(tap) : '0);
    emit1 = (s1_row_m >= hh_m) && (s1_col_m >= hw_m);
    tail_start_m = (s1_col_m >= hw_m) ? (s1_col_m - hw_m + MW'(1)) : '0;
    tail_go = (s1_row_m >= hh_m) && (s1_col_m == w_m - MW'(1)) && (tail_start_m < w_m);
    s1_go = s1_valid && (!emit1 || out_free);
    rs_tail = row_sum - ((MW'(tail_col) >= hw_m + MW'(1)) ? SW'(tap) : '0);
    tail_step = tail_active && out_free;
  end

  assign pix_in.ready = !tail_active && (!s1_valid || (s1_go && !tail_go));

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_row  <= v0;
      s1_col  <= u0;
      s1_pix  <= p0;
      s1_addr <= addr0;
      pix_rd  <= (s1_go && (s1_addr == addr0)) ? s1_pix : pix_mem[addr0];
      col_rd  <= (s1_go && (s1_col == u0)) ? cs_new : col_mem[u0[CW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      pix_mem[s1_addr]          <= s1_pix;
      col_mem[s1_col[CW-1:0]]   <= cs_new;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go || tail_step) begin
      line_q[0] <= s1_go ? cs_new : '0;
      for (int k = 1; k < LW; k++) begin
        line_q[k] <= line_q[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      tail_active <= 1'b0;
      row_sum     <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go) begin
        row_sum <= rs_new;
        if (tail_go) begin
          tail_active <= 1'b1;
        end
      end else if (tail_step) begin
        row_sum <= rs_tail;
        if (MW'(tail_col) == w_m - MW'(1)) begin
          tail_active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && tail_go) begin
      tail_col <= WB'(tail_start_m);
      tail_row <= s1_row - RW'(hh);
    end else if (tail_step) begin
      tail_col <= tail_col + WB'(1);
    end
  end

  // Output register.
  logic [RW-1:0] res_row;
  logic [WB-1:0] res_col;
  logic [SW-1:0] res_sum;
  logic          res_load;

  always_comb begin
    res_load = (s1_go && emit1) || tail_step;
    if (tail_active) begin
      res_row = tail_row;
      res_col = tail_col;
      res_sum = rs_tail;
    end else begin
      res_row = s1_row - RW'(hh);
      res_col = WB'(s1_col_m - hw_m);
      res_sum = rs_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (res_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_out.box_sum    <= res_sum;
      res_out.centre_row <= bfws_pkg::CROW_W'(res_row);
      res_out.centre_col <= bfws_pkg::CCOL_W'(res_col);
      res_out.frame_done <= (res_row == h - RW'(1)) && (MW'(res_col) == w_m - MW'(1));
    end
  end

  assign res_out.valid = out_valid;

endmodule
